// ===== hdl/owbm_pkg.sv =====
// Package: phase codes, op codes, register indexes and engine state types.
package owbm_pkg;

    // Bus phases of the timing engine
    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_RST_LOW     = 4'd1,
        PH_RST_WAIT    = 4'd2,
        PH_RST_SAMPLE  = 4'd3,
        PH_RST_RECOVER = 4'd4,
        PH_SLOT_LOW    = 4'd5,
        PH_WR_HOLD     = 4'd6,
        PH_WR_REC      = 4'd7,
        PH_RD_DELAY    = 4'd8,
        PH_RD_SAMPLE   = 4'd9,
        PH_RD_REC      = 4'd10,
        PH_END         = 4'd11,
        PH_BITEND      = 4'd12
    } t_phase;

    // Command codes
    localparam logic [2:0] OP_RESET      = 3'd0;
    localparam logic [2:0] OP_WRITE_BIT  = 3'd1;
    localparam logic [2:0] OP_READ_BIT   = 3'd2;
    localparam logic [2:0] OP_WRITE_BYTE = 3'd3;
    localparam logic [2:0] OP_READ_BYTE  = 3'd4;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_RESET_LOW      = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
    localparam logic [2:0] REG_PRESENCE_WIN   = 3'd2;
    localparam logic [2:0] REG_RESET_RECOVERY = 3'd3;
    localparam logic [2:0] REG_SLOT_START_LOW = 3'd4;
    localparam logic [2:0] REG_WRITE_SLOT     = 3'd5;
    localparam logic [2:0] REG_READ_DELAY     = 3'd6;
    localparam logic [2:0] REG_READ_WINDOW    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TIMER_W    = 10;

    // Configuration registers
    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_wait;
        logic [7:0] presence_window;
        logic [9:0] reset_recovery;
        logic [5:0] slot_start_low;
        logic [7:0] write_slot_time;
        logic [5:0] read_sample_delay;
        logic [7:0] read_window;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_low_time:    10'd500,
        presence_wait:     8'd15,
        presence_window:   8'd55,
        reset_recovery:    10'd430,
        slot_start_low:    6'd6,
        write_slot_time:   8'd80,
        read_sample_delay: 6'd4,
        read_window:       8'd40
    };

    // Engine state carried from item to item
    typedef struct packed {
        t_phase               phase;
        logic [TIMER_W-1:0]   timer;
        logic [3:0]           bits_left;
        logic [7:0]           shift_data;
        logic [2:0]           cur_op;
        logic                 saw_low;
        logic                 presence;
        logic [7:0]           read_hold;
    } t_eng_state;

    localparam t_eng_state ENG_RESET = '{
        phase: PH_IDLE, timer: '0, bits_left: '0, shift_data: '0,
        cur_op: OP_RESET, saw_low: 1'b0, presence: 1'b0, read_hold: '0
    };

    // Result of one item
    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_data;
    } t_result;

endpackage

// ===== hdl/owbm_engine.sv =====
// Next-state logic of the timing engine for one tick or command beat.
module owbm_engine #(
    parameter int WRITE_RECOVERY = 60,
    parameter int READ_RECOVERY  = 60
) (
    input  owbm_pkg::t_cfg       i_cfg,
    input  owbm_pkg::t_eng_state i_state,
    input  logic                 i_kind,
    input  logic [2:0]           i_op,
    input  logic [7:0]           i_data,
    input  logic                 i_line_sample,
    output owbm_pkg::t_eng_state o_state,
    output owbm_pkg::t_result    o_result
);
    import owbm_pkg::*;

    localparam logic [TIMER_W-1:0] WR_REC_LEN = TIMER_W'(WRITE_RECOVERY);
    localparam logic [TIMER_W-1:0] RD_REC_LEN = TIMER_W'(READ_RECOVERY);
    // enough steps to walk any run of empty phases
    localparam int WALK_STEPS = 6;

    // Length of a phase in microseconds
    function automatic logic [TIMER_W-1:0] phase_len(input t_phase p, input t_cfg c);
        logic [TIMER_W-1:0] len;
        case (p)
            PH_RST_LOW:     len = c.reset_low_time;
            PH_RST_WAIT:    len = TIMER_W'(c.presence_wait);
            PH_RST_SAMPLE:  len = TIMER_W'(c.presence_window);
            PH_RST_RECOVER: len = c.reset_recovery;
            PH_SLOT_LOW:    len = TIMER_W'(c.slot_start_low);
            PH_WR_HOLD:     len = TIMER_W'(c.write_slot_time);
            PH_WR_REC:      len = WR_REC_LEN;
            PH_RD_DELAY:    len = TIMER_W'(c.read_sample_delay);
            PH_RD_SAMPLE:   len = TIMER_W'(c.read_window);
            PH_RD_REC:      len = RD_REC_LEN;
            default:        len = '0;
        endcase
        return len;
    endfunction

    // Exit actions of the current phase; the phase field comes back as the next one
    function automatic t_eng_state leave_phase(input t_eng_state st);
        t_eng_state s;
        logic       is_wr;
        logic       bit_rd;
        s      = st;
        is_wr  = (st.cur_op == OP_WRITE_BIT) || (st.cur_op == OP_WRITE_BYTE);
        bit_rd = ~st.saw_low;
        case (st.phase)
            PH_RST_LOW:     s.phase = PH_RST_WAIT;
            PH_RST_WAIT:    s.phase = PH_RST_SAMPLE;
            PH_RST_SAMPLE: begin
                s.presence = st.saw_low;
                s.phase    = PH_RST_RECOVER;
            end
            PH_RST_RECOVER: s.phase = PH_END;
            PH_SLOT_LOW:    s.phase = is_wr ? PH_WR_HOLD : PH_RD_DELAY;
            PH_WR_HOLD:     s.phase = PH_WR_REC;
            PH_WR_REC:      s.phase = PH_BITEND;
            PH_RD_DELAY:    s.phase = PH_RD_SAMPLE;
            PH_RD_SAMPLE: begin
                if (st.cur_op == OP_READ_BYTE) begin
                    s.shift_data = {bit_rd, st.shift_data[7:1]};
                end else begin
                    s.shift_data = {7'd0, bit_rd};
                end
                s.phase = PH_RD_REC;
            end
            PH_RD_REC:      s.phase = PH_BITEND;
            PH_BITEND: begin
                if (is_wr) begin
                    s.shift_data = {1'b0, st.shift_data[7:1]};
                end
                s.bits_left = (st.bits_left != 4'd0) ? st.bits_left - 4'd1 : 4'd0;
                if (s.bits_left != 4'd0) begin
                    s.saw_low = 1'b0;
                    s.phase   = PH_SLOT_LOW;
                end else begin
                    s.phase = PH_END;
                end
            end
            default:        s.phase = PH_END;
        endcase
        return s;
    endfunction

    t_eng_state         s;
    logic               walk;
    logic               stop;
    logic               done;
    logic [TIMER_W-1:0] len;

    // Apply the beat, then walk through empty phases to the next timed one
    always_comb begin
        s    = i_state;
        walk = 1'b0;
        stop = 1'b0;
        done = 1'b0;
        len  = '0;
        if (i_kind == KIND_CMD) begin
            if (i_state.phase == PH_IDLE && i_op inside {[OP_RESET:OP_READ_BYTE]}) begin
                s.cur_op  = i_op;
                s.saw_low = 1'b0;
                walk      = 1'b1;
                if (i_op == OP_RESET) begin
                    s.bits_left  = 4'd0;
                    s.shift_data = 8'd0;
                    s.phase      = PH_RST_LOW;
                end else begin
                    s.bits_left = (i_op inside {OP_WRITE_BYTE, OP_READ_BYTE}) ? 4'd8 : 4'd1;
                    case (i_op)
                        OP_WRITE_BIT:  s.shift_data = {7'd0, i_data[0]};
                        OP_WRITE_BYTE: s.shift_data = i_data;
                        default:       s.shift_data = 8'd0;
                    endcase
                    s.phase = PH_SLOT_LOW;
                end
            end
        end else if (i_state.phase != PH_IDLE) begin
            if ((i_state.phase inside {PH_RST_SAMPLE, PH_RD_SAMPLE}) && !i_line_sample) begin
                s.saw_low = 1'b1;
            end
            if (s.timer != '0) begin
                s.timer = s.timer - TIMER_W'(1);
            end
            if (s.timer == '0) begin
                s    = leave_phase(s);
                walk = 1'b1;
            end
        end

        for (int k = 0; k < WALK_STEPS; k++) begin
            if (walk && !stop) begin
                len = phase_len(s.phase, i_cfg);
                if (s.phase == PH_END) begin
                    if (s.cur_op inside {OP_READ_BIT, OP_READ_BYTE}) begin
                        s.read_hold = s.shift_data;
                    end
                    s.phase = PH_IDLE;
                    s.timer = '0;
                    done    = 1'b1;
                    stop    = 1'b1;
                end else if (len != '0) begin
                    s.timer = len;
                    stop    = 1'b1;
                end else begin
                    s = leave_phase(s);
                end
            end
        end
    end

    assign o_state = s;

    // Line level for the coming microsecond and status
    always_comb begin
        case (s.phase)
            PH_RST_LOW, PH_SLOT_LOW: o_result.drive_low = 1'b1;
            PH_WR_HOLD:              o_result.drive_low = ~s.shift_data[0];
            default:                 o_result.drive_low = 1'b0;
        endcase
        o_result.busy      = (s.phase != PH_IDLE);
        o_result.done      = done;
        o_result.presence  = s.presence;
        o_result.read_data = s.read_hold;
    end

endmodule

// ===== hdl/one_wire_bus_master_unit.sv =====
// Top level of the 1-Wire bus master timing engine.
//
//  Channel   Direction  Handshake               Beat
//  item      in         i_in_valid/o_in_stall   kind, op, data, line_sample
//  result    out        o_out_valid/i_out_stall drive_low, busy, done, presence, read_data
//  config    in         i_cfg_wr_en             i_cfg_index, i_cfg_data
//
// One beat is taken every cycle while o_in_stall is low; each item passes the
// input register, then the result register after the engine logic.
// Every item gives exactly one result. Reset (synchronous, active low)
// empties both registers, idles the engine and loads the default timings.
// A stall on the result side holds the result register and then, once the
// input register is full, stalls the item side.
module one_wire_bus_master_unit #(
    parameter int WRITE_RECOVERY = 60,
    parameter int READ_RECOVERY  = 60
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [2:0]                     i_op,
    input  logic [7:0]                     i_data,
    input  logic                           i_line_sample,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_drive_low,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_presence,
    output logic [7:0]                     o_read_data,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [owbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import owbm_pkg::*;

    t_cfg       r_cfg;
    t_eng_state r_state;
    t_eng_state n_state;
    t_result    n_result;
    t_result    r_result;

    logic       r_in_valid;
    logic       r_kind;
    logic [2:0] r_op;
    logic [7:0] r_data;
    logic       r_line_sample;
    logic       r_out_valid;

    logic       out_free;
    logic       take;

    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign take       = r_in_valid & out_free;
    assign o_in_stall = r_in_valid & ~out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_RESET_LOW:      r_cfg.reset_low_time    <= i_cfg_data;
                REG_PRESENCE_WAIT:  r_cfg.presence_wait     <= i_cfg_data[7:0];
                REG_PRESENCE_WIN:   r_cfg.presence_window   <= i_cfg_data[7:0];
                REG_RESET_RECOVERY: r_cfg.reset_recovery    <= i_cfg_data;
                REG_SLOT_START_LOW: r_cfg.slot_start_low    <= i_cfg_data[5:0];
                REG_WRITE_SLOT:     r_cfg.write_slot_time   <= i_cfg_data[7:0];
                REG_READ_DELAY:     r_cfg.read_sample_delay <= i_cfg_data[5:0];
                REG_READ_WINDOW:    r_cfg.read_window       <= i_cfg_data[7:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_kind        <= i_kind;
            r_op          <= i_op;
            r_data        <= i_data;
            r_line_sample <= i_line_sample;
        end
    end

    owbm_engine #(
        .WRITE_RECOVERY (WRITE_RECOVERY),
        .READ_RECOVERY  (READ_RECOVERY)
    ) u_engine (
        .i_cfg         (r_cfg),
        .i_state       (r_state),
        .i_kind        (r_kind),
        .i_op          (r_op),
        .i_data        (r_data),
        .i_line_sample (r_line_sample),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // Engine state advances once per item beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_RESET;
        end else if (take) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive_low = r_result.drive_low;
    assign o_busy_res  = r_result.busy;
    assign o_done_res  = r_result.done;
    assign o_presence  = r_result.presence;
    assign o_read_data = r_result.read_data;

endmodule

// ===== hdl/owbm_checker.sv =====
// Port-level checks of the bus master unit and their bind.
module owbm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_drive_low,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic       o_presence,
    input logic [7:0] o_read_data
);

    // a finished command leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done beat shows engine busy");

    // the line is only pulled low during a command
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_low |-> o_busy_res)
        else $error("line driven low while idle");

    // item side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("item stall without result back-pressure");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data)
            && $stable(o_presence) && $stable(o_done_res) && $stable(o_drive_low))
        else $error("stalled result beat changed");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive_low (o_drive_low),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_presence  (o_presence),
    .o_read_data (o_read_data)
);
